>>> rtl/refcounted_handle_allocator_macros.svh
// assertion macros for the handle allocator rtl
// no dependencies; included by the controller and datapath
`ifndef REFCOUNTED_HANDLE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/rha_pkg.sv
// shared types, codes and constants of the handle allocator
// no dependencies
`default_nettype none

package rha_pkg;

	localparam int ENTRIES_DEF = 4096;
	localparam int PAGE_BYTES  = 4096;
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int ROW_BITS    = 64;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [1:0] {
		MD_CREATE = 2'd0,
		MD_CLOSE  = 2'd1,
		MD_IMPORT = 2'd2,
		MD_LOOKUP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOALLOC  = 3'd3,
		ST_UNUSED   = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_RD   = 2'd1,
		S_EX   = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [15:0] refcount;
		logic [47:0] addr;
		logic [20:0] pages;
	} entry_t;

	function automatic logic [20:0] pages_of(input logic [31:0] size);
		logic [32:0] p;
		logic [31:0] rem_mask;
		rem_mask = 32'(PAGE_BYTES - 1);
		p = 33'(size >> PAGE_SHIFT) + 33'(|(size & rem_mask));
		pages_of = (p > 33'h1FFFFF) ? 21'h1FFFFF : p[20:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/rha_ctrl.sv
// controller state machine: accept, read, update-and-report
// depends on rha_pkg and the assertion macro header
`default_nettype none
`include "refcounted_handle_allocator_macros.svh"

module rha_ctrl
	import rha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output ctl_cmd_t      cmd,
	input  wire dp_stat_t stat
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.read    = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.read = 1'b1;
				state_d  = S_EX;
			end
			S_EX: begin
				cmd.commit = stat.out_free;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`RHA_ASSERT_NXT(a_accept_reads, clk, arst_n, s_tvalid && s_tready, state_q == S_RD, "accepted transfer not followed by table read")
	`RHA_ASSERT_NXT(a_hold_result, clk, arst_n, (state_q == S_EX) && !stat.out_free, state_q == S_EX, "result dropped while output busy")

endmodule

`default_nettype wire

>>> rtl/rha_datapath.sv
// datapath: request registers, occupancy bitmap, slot store, output register
// depends on rha_pkg and the assertion macro header
`default_nettype none
`include "refcounted_handle_allocator_macros.svh"

module rha_datapath
	import rha_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_cmd_t              cmd,
	output dp_stat_t                   stat,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ROWS   = (ENTRIES + ROW_BITS - 1) / ROW_BITS;
	localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RDEPTH = 2 ** RW;
	localparam int BW     = $clog2(ROW_BITS);
	localparam int CW     = RW + BW;
	localparam int LAST_CNT = ENTRIES - (ROWS - 1) * ROW_BITS;
	localparam logic [ROW_BITS-1:0] LAST_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - LAST_CNT);
	localparam logic [RDEPTH-1:0]   ROW_EXIST = {RDEPTH{1'b1}} >> (RDEPTH - ROWS);

	// request registers
	mode_t       req_mode_q;
	logic [31:0] req_size_q;
	logic [47:0] req_addr_q;
	logic [15:0] req_handle_q;

	// storage
	logic [ROW_BITS-1:0] bitmap_mem [RDEPTH];
	entry_t              slot_mem [ENTRIES];
	logic [RDEPTH-1:0]   row_valid_q;
	logic [RDEPTH-1:0]   row_full_q;

	// read results
	logic [ROW_BITS-1:0] bm_row_q;
	logic                rowv_q;
	logic [RW-1:0]       row_sel_q;
	logic                full_q;
	logic                hok_q;
	entry_t              ent_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// read-side logic
	logic          handle_ok;
	logic [CW-1:0] hslot;
	logic [RDEPTH-1:0] free_rows;
	logic [RW-1:0] first_row;
	logic          any_free;
	logic [RW-1:0] rd_row;

	always_comb begin
		handle_ok = (req_handle_q != 16'd0) && ({1'b0, req_handle_q} <= 17'(ENTRIES));
		hslot     = CW'(req_handle_q - 16'd1);
		free_rows = ~row_full_q & ROW_EXIST;
		any_free  = |free_rows;
		first_row = '0;
		for (int i = RDEPTH - 1; i >= 0; i--) begin
			if (free_rows[i]) begin
				first_row = RW'(i);
			end
		end
		rd_row = (req_mode_q == MD_CREATE) ? first_row : hslot[CW-1:BW];
	end

	// update-side logic
	logic [ROW_BITS-1:0] row_mask;
	logic [ROW_BITS-1:0] row_bits;
	logic [ROW_BITS-1:0] row_occ;
	logic [BW-1:0]       fbit;
	logic [CW-1:0]       new_slot;
	logic                in_use;
	logic                create_ok;
	logic                bm_we;
	logic [ROW_BITS-1:0] bm_wdata;
	logic                dm_we;
	logic [SW-1:0]       dm_waddr;
	entry_t              dm_wdata;
	status_t             res_status;
	logic [12:0]         res_handle;
	logic [47:0]         res_addr;
	logic [20:0]         res_pages;
	logic                res_freed;
	logic [15:0]         cnt_dec;
	logic [16:0]         hsum_new;
	logic [16:0]         hsum_req;

	always_comb begin
		row_mask = (row_sel_q == RW'(ROWS - 1)) ? LAST_MASK : {ROW_BITS{1'b1}};
		row_bits = rowv_q ? bm_row_q : '0;
		row_occ  = row_bits | ~row_mask;
		fbit     = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (!row_occ[i]) begin
				fbit = BW'(i);
			end
		end
		new_slot  = {row_sel_q, fbit};
		in_use    = row_bits[hslot[BW-1:0]];
		cnt_dec   = ent_q.refcount - 16'd1;
		hsum_new  = 17'(new_slot) + 17'd1;
		hsum_req  = 17'(hslot) + 17'd1;
		create_ok = 1'b0;
		bm_we     = 1'b0;
		bm_wdata  = row_bits;
		dm_we     = 1'b0;
		dm_waddr  = hslot[SW-1:0];
		dm_wdata  = ent_q;
		res_status = ST_OK;
		res_handle = '0;
		res_addr   = '0;
		res_pages  = '0;
		res_freed  = 1'b0;
		case (req_mode_q)
			MD_CREATE: begin
				dm_waddr = new_slot[SW-1:0];
				if (req_size_q == 32'd0) begin
					res_status = ST_BAD;
				end else if (full_q) begin
					res_status = ST_FULL;
				end else if (req_addr_q == 48'd0) begin
					res_status = ST_NOALLOC;
				end else begin
					create_ok        = 1'b1;
					bm_we            = 1'b1;
					bm_wdata[fbit]   = 1'b1;
					dm_we            = 1'b1;
					dm_wdata.refcount = 16'd1;
					dm_wdata.addr    = req_addr_q;
					dm_wdata.pages   = pages_of(req_size_q);
					res_handle       = hsum_new[12:0];
				end
			end
			MD_CLOSE, MD_IMPORT, MD_LOOKUP: begin
				if (!hok_q) begin
					res_status = ST_BAD;
				end else if (!in_use) begin
					res_status = ST_UNUSED;
				end else if (req_mode_q == MD_CLOSE) begin
					dm_we             = 1'b1;
					dm_wdata.refcount = cnt_dec;
					if (cnt_dec == 16'd0) begin
						bm_we                    = 1'b1;
						bm_wdata[hslot[BW-1:0]]  = 1'b0;
						res_freed                = 1'b1;
					end
				end else if (req_mode_q == MD_IMPORT) begin
					if (ent_q.refcount == 16'hFFFF) begin
						res_status = ST_OVERFLOW;
					end else begin
						dm_we             = 1'b1;
						dm_wdata.refcount = ent_q.refcount + 16'd1;
						res_handle        = hsum_req[12:0];
					end
				end else begin
					res_addr  = ent_q.addr;
					res_pages = ent_q.pages;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	// request capture, memory reads and writes, and output data load
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_mode_q   <= mode_t'(s_tuser);
			req_size_q   <= s_tdata[31:0];
			req_addr_q   <= s_tdata[79:32];
			req_handle_q <= s_tdata[95:80];
		end
		if (cmd.read) begin
			bm_row_q  <= bitmap_mem[rd_row];
			ent_q     <= slot_mem[hslot[SW-1:0]];
			rowv_q    <= row_valid_q[rd_row];
			row_sel_q <= rd_row;
			full_q    <= !any_free;
			hok_q     <= handle_ok;
		end
		if (cmd.commit && bm_we) begin
			bitmap_mem[row_sel_q] <= bm_wdata;
		end
		if (cmd.commit && dm_we) begin
			slot_mem[dm_waddr] <= dm_wdata;
		end
		if (cmd.commit) begin
			out_data_q <= {2'b00, res_freed, res_pages, res_addr, res_handle, res_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_full_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && bm_we) begin
				row_valid_q[row_sel_q] <= 1'b1;
				row_full_q[row_sel_q]  <= &(bm_wdata | ~row_mask);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;

	`RHA_ASSERT_IMP(a_slot_range, clk, arst_n, cmd.commit && create_ok, 32'(new_slot) < 32'(ENTRIES), "created slot beyond table")
	`RHA_ASSERT_NXT(a_out_load, clk, arst_n, cmd.commit, out_valid_q, "committed result not presented")

endmodule

`default_nettype wire

>>> rtl/refcounted_handle_allocator.sv
// each request passes through accept, a registered read of the bitmap and slot store,
// and an update that writes them back and loads the output register; the update waits
// while the output holds a result not yet taken, and the next request is accepted only
// after the update; a new request is taken while the previous result still waits at the output
// reset clears the controller, row-valid and row-full flags and the output valid;
// the store needs no clearing pass
`default_nettype none

module refcounted_handle_allocator
	import rha_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // size_bytes, phys_addr, handle
	input  wire logic [1:0]            s_axis_tuser,  // mode
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // status, handle_out, address_out,
	                                                  // size_pages_out, freed
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	rha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rha_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire
